/* hw/rtl/vqdm_pkg.sv */
// shared constants and types for the virtqueue descriptor manager
`timescale 1ns / 1ps
package vqdm_pkg;
    localparam int QUEUE_MAX_DEF = 256;

    localparam logic [1:0] CMD_ADD  = 2'd0;
    localparam logic [1:0] CMD_USED = 2'd1;
    localparam logic [1:0] CMD_DEQ  = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_DROP  = 2'd3;

    localparam logic CFG_QSIZE = 1'b0;
    localparam logic CFG_QID   = 1'b1;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  desc_index;
        logic        posted;
        logic [7:0]  avail_slot;
        logic [15:0] notify_queue;
        logic [63:0] cookie_out;
        logic [31:0] used_len_out;
    } result_t;
endpackage

/* hw/rtl/vqdm_alloc.sv */
// allocation bitmap with lowest-free search and per-entry set and clear
`timescale 1ns / 1ps
module vqdm_alloc #(
    parameter int QUEUE_MAX = vqdm_pkg::QUEUE_MAX_DEF,
    localparam int IW = (QUEUE_MAX > 256) ? $clog2(QUEUE_MAX) : 8,
    localparam int NE = 1 << IW
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [IW:0]   size,
    input  logic          set_en,
    input  logic [IW-1:0] set_idx,
    input  logic          clr_en,
    input  logic [IW-1:0] clr_idx,
    output logic          found,
    output logic [IW-1:0] free_idx
);
    logic [NE-1:0] map_reg;
    logic [NE-1:0] map_next;

    always_comb begin
        map_next = map_reg;
        if (set_en) begin
            map_next[set_idx] = 1'b1;
        end
        if (clr_en) begin
            map_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_reg <= '0;
        end else begin
            map_reg <= map_next;
        end
    end

    always_comb begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = NE - 1; i >= 0; i--) begin
            if (!map_reg[i] && ((IW + 1)'(i) < size)) begin
                found    = 1'b1;
                free_idx = IW'(i);
            end
        end
    end
endmodule

/* hw/rtl/virtqueue_descriptor_manager.sv */
// top level of the virtqueue descriptor manager
// throughput: one item at a time; the next item is accepted no earlier than its result beat is taken
// reset: synchronous active low; clears indexes, chain state and allocation map
// memory contents are not cleared; no clearing pass
`timescale 1ns / 1ps
module virtqueue_descriptor_manager #(
    parameter int QUEUE_MAX = vqdm_pkg::QUEUE_MAX_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_seg_addr,
    input  logic [31:0] s_seg_len,
    input  logic        s_device_writes,
    input  logic        s_last_segment,
    input  logic [63:0] s_cookie_in,
    input  logic [7:0]  s_used_head,
    input  logic [31:0] s_used_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [7:0]  m_desc_index,
    output logic        m_posted,
    output logic [7:0]  m_avail_slot,
    output logic [15:0] m_notify_queue,
    output logic [63:0] m_cookie_out,
    output logic [31:0] m_used_len_out
);
    localparam int IW = (QUEUE_MAX > 256) ? $clog2(QUEUE_MAX) : 8;
    localparam int NE = 1 << IW;
    localparam int MAXL = $clog2(QUEUE_MAX + 1) - 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DRD   = 3'd2;
    localparam logic [2:0] S_DEQ   = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;
    localparam logic [2:0] S_WRT   = 3'd6;
    localparam logic [2:0] S_CHK   = 3'd7;

    logic [3:0]  qlog_reg;
    logic [15:0] qid_reg;

    // memories
    logic [63:0] m_addr [NE];
    logic [31:0] m_len  [NE];
    logic        m_wflag[NE];
    logic        m_nflag[NE];
    logic [IW-1:0] m_link[NE];
    logic [63:0] m_cookie[NE];
    logic [IW-1:0] m_avail[NE];
    logic [IW-1:0] m_uhead[NE];
    logic [31:0] m_ulen [NE];

    logic [2:0]  state_reg;
    logic [1:0]  cmd_reg;
    logic [63:0] addr_reg;
    logic [31:0] len_reg;
    logic        dw_reg;
    logic        last_reg;
    logic [63:0] cookie_reg;
    logic [7:0]  uhead_reg;
    logic [31:0] ulen_reg;

    logic [15:0] avail_idx_reg;
    logic [15:0] used_idx_reg;
    logic [15:0] seen_reg;
    logic [IW-1:0] first_reg;
    logic [IW-1:0] tail_reg;
    logic        inreq_reg;
    logic        drop_reg;

    logic [IW-1:0] walk_reg;
    logic [IW:0]   steps_reg;
    logic          nflag_rd;
    logic [IW-1:0] link_rd;
    logic [IW-1:0] uhead_rd;
    logic [31:0]   ulen_rd;
    logic [63:0]   cookie_rd;

    vqdm_pkg::result_t res_reg;
    logic        rv_reg;

    // queue size
    logic [3:0] qe;
    logic [IW:0] size;
    always_comb begin
        qe = (qlog_reg == 4'd0) ? 4'd1 : qlog_reg;
        if (32'(qe) > MAXL) begin
            qe = 4'(MAXL);
        end
        size = (IW + 1)'(1) << qe;
    end
    logic [IW-1:0] smask;
    assign smask = IW'(size - (IW + 1)'(1));

    logic found;
    logic [IW-1:0] free_idx;
    logic set_en, clr_en;
    logic [IW-1:0] clr_idx;

    vqdm_alloc #(.QUEUE_MAX(QUEUE_MAX)) u_alloc (
        .aclk(aclk), .aresetn(aresetn), .size(size),
        .set_en(set_en), .set_idx(free_idx),
        .clr_en(clr_en), .clr_idx(clr_idx),
        .found(found), .free_idx(free_idx)
    );

    assign s_ready = (state_reg == S_IDLE) && (!rv_reg || m_ready);
    wire acc = s_valid && s_ready;

    assign set_en = (state_reg == S_EXEC) && (cmd_reg == vqdm_pkg::CMD_ADD) && !drop_reg
                    && found;
    assign clr_en = (state_reg == S_WALK);
    assign clr_idx = walk_reg;

    wire [IW-1:0] uslot = IW'(used_idx_reg) & smask;
    wire [IW-1:0] sslot = IW'(seen_reg) & smask;
    wire [IW-1:0] aslot = IW'(avail_idx_reg) & smask;

    // memory read ports
    always_ff @(posedge aclk) begin
        nflag_rd  <= m_nflag[walk_reg];
        link_rd   <= m_link[walk_reg];
        uhead_rd  <= m_uhead[sslot];
        ulen_rd   <= m_ulen[sslot];
        cookie_rd <= m_cookie[uhead_rd];
    end

    // memory writes
    always_ff @(posedge aclk) begin
        if (state_reg == S_EXEC && cmd_reg == vqdm_pkg::CMD_ADD && !drop_reg && found) begin
            m_addr[free_idx]  <= addr_reg;
            m_len[free_idx]   <= len_reg;
            m_wflag[free_idx] <= dw_reg;
            m_nflag[free_idx] <= 1'b0;
            m_link[free_idx]  <= '0;
            if (last_reg) begin
                m_avail[aslot] <= inreq_reg ? first_reg : free_idx;
            end
        end
        if (state_reg == S_WRT) begin
            m_nflag[tail_reg] <= 1'b1;
            m_link[tail_reg]  <= walk_reg;
            if (last_reg) begin
                m_cookie[first_reg] <= cookie_reg;
            end
        end
        if (state_reg == S_EXEC && cmd_reg == vqdm_pkg::CMD_ADD && !drop_reg && found
            && last_reg && !inreq_reg) begin
            m_cookie[free_idx] <= cookie_reg;
        end
        if (state_reg == S_EXEC && cmd_reg == vqdm_pkg::CMD_USED) begin
            m_uhead[uslot] <= IW'(uhead_reg);
            m_ulen[uslot]  <= ulen_reg;
        end
        if (state_reg == S_DEQ) begin
            m_cookie[IW'(uhead_rd)] <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            cmd_reg    <= s_command;
            addr_reg   <= s_seg_addr;
            len_reg    <= s_seg_len;
            dw_reg     <= s_device_writes;
            last_reg   <= s_last_segment;
            cookie_reg <= s_cookie_in;
            uhead_reg  <= s_used_head;
            ulen_reg   <= s_used_length;
        end
    end

    always_ff @(posedge aclk) begin
        vqdm_pkg::result_t res_v;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            qlog_reg      <= 4'd8;
            qid_reg       <= '0;
            avail_idx_reg <= '0;
            used_idx_reg  <= '0;
            seen_reg      <= '0;
            first_reg     <= '0;
            tail_reg      <= '0;
            inreq_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            rv_reg        <= 1'b0;
            walk_reg      <= '0;
            steps_reg     <= '0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == vqdm_pkg::CFG_QSIZE) begin
                    qlog_reg <= cfg_data[3:0];
                end else begin
                    qid_reg <= cfg_data;
                end
            end
            if (rv_reg && m_ready) begin
                rv_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    res_v = '0;
                    case (cmd_reg)
                        vqdm_pkg::CMD_ADD: begin
                            if (drop_reg) begin
                                res_v.status = vqdm_pkg::ST_DROP;
                                if (last_reg) begin
                                    drop_reg <= 1'b0;
                                end
                                state_reg <= S_OUT;
                            end else if (!found) begin
                                res_v.status = vqdm_pkg::ST_NOFREE;
                                inreq_reg <= 1'b0;
                                drop_reg  <= !last_reg;
                                if (inreq_reg) begin
                                    walk_reg  <= first_reg;
                                    steps_reg <= '0;
                                    state_reg <= S_WALK;
                                end else begin
                                    state_reg <= S_OUT;
                                end
                            end else begin
                                res_v.desc_index = 8'(free_idx);
                                walk_reg <= free_idx;
                                if (!inreq_reg) begin
                                    first_reg <= free_idx;
                                    tail_reg  <= free_idx;
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_WRT;
                                end
                                inreq_reg <= !last_reg;
                                if (last_reg) begin
                                    avail_idx_reg <= avail_idx_reg + 16'd1;
                                    res_v.posted = 1'b1;
                                    res_v.avail_slot = 8'(aslot);
                                    res_v.notify_queue = qid_reg;
                                end
                            end
                        end
                        vqdm_pkg::CMD_USED: begin
                            used_idx_reg <= used_idx_reg + 16'd1;
                            state_reg <= S_OUT;
                        end
                        vqdm_pkg::CMD_DEQ: begin
                            if (used_idx_reg == seen_reg) begin
                                res_v.status = vqdm_pkg::ST_EMPTY;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_DRD;
                            end
                        end
                        default: state_reg <= S_OUT;
                    endcase
                    res_reg <= res_v;
                end
                S_WRT: begin
                    tail_reg  <= walk_reg;
                    if (last_reg) begin
                        inreq_reg <= 1'b0;
                    end
                    state_reg <= S_OUT;
                end
                S_DRD: begin
                    walk_reg  <= IW'(uhead_rd);
                    state_reg <= S_DEQ;
                end
                S_DEQ: begin
                    res_v = res_reg;
                    res_v.desc_index   = 8'(uhead_rd);
                    res_v.cookie_out   = cookie_rd;
                    res_v.used_len_out = ulen_rd;
                    res_reg   <= res_v;
                    seen_reg  <= seen_reg + 16'd1;
                    steps_reg <= '0;
                    state_reg <= S_WALK;
                end
                S_WALK: begin
                    // descriptor flags read this cycle, next cycle decides
                    steps_reg <= steps_reg + (IW + 1)'(1);
                    state_reg <= S_CHK;
                end
                S_CHK: begin
                    if (!nflag_rd || steps_reg == (IW + 1)'(NE)) begin
                        state_reg <= S_OUT;
                    end else begin
                        walk_reg  <= link_rd;
                        state_reg <= S_WALK;
                    end
                end
                S_OUT: begin
                    if (!rv_reg || m_ready) begin
                        rv_reg    <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_valid        = rv_reg;
    assign m_status       = res_reg.status;
    assign m_desc_index   = res_reg.desc_index;
    assign m_posted       = res_reg.posted;
    assign m_avail_slot   = res_reg.avail_slot;
    assign m_notify_queue = res_reg.notify_queue;
    assign m_cookie_out   = res_reg.cookie_out;
    assign m_used_len_out = res_reg.used_len_out;
endmodule

/* tb/vqdm_checker.sv */
// scoreboard for the virtqueue descriptor manager: predicts each result and compares it
`timescale 1ns / 1ps
module vqdm_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic        s_last_segment,
    input  logic [63:0] s_cookie_in,
    input  logic [7:0]  s_used_head,
    input  logic [31:0] s_used_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [7:0]  m_desc_index,
    input  logic        m_posted,
    input  logic [7:0]  m_avail_slot,
    input  logic [15:0] m_notify_queue,
    input  logic [63:0] m_cookie_out,
    input  logic [31:0] m_used_len_out,
    output int          mismatches,
    output int          outstanding
);
    localparam int DEPTH = 256;

    logic [3:0]  qsize_log2;
    logic [15:0] qid;
    bit          in_use [DEPTH];
    bit          has_next [DEPTH];
    logic [7:0]  next_desc [DEPTH];
    logic [63:0] cookies [DEPTH];
    logic [7:0]  completion_head [DEPTH];
    logic [31:0] completion_len [DEPTH];
    logic [15:0] avail_idx;
    logic [15:0] used_idx;
    logic [15:0] seen_idx;
    logic [7:0]  chain_head;
    logic [7:0]  chain_last;
    bit          building;
    bit          discarding;
    vqdm_pkg::result_t expected_results [$];
    int          fail_count;

    function automatic int ring_size();
        int e;
        e = qsize_log2;
        if (e < 1) e = 1;
        while (e > 1 && (1 << e) > vqdm_pkg::QUEUE_MAX_DEF) e--;
        return 1 << e;
    endfunction

    task automatic release_chain(input logic [7:0] start);
        logic [7:0] d;
        int steps;
        d = start;
        for (steps = 0; steps < DEPTH; steps++) begin
            in_use[d] = 0;
            if (!has_next[d]) return;
            d = next_desc[d];
        end
    endtask

    task automatic predict_result(output vqdm_pkg::result_t r);
        int size;
        int d;
        int slot;
        size = ring_size();
        r = '0;
        case (s_command)
            vqdm_pkg::CMD_ADD: begin
                if (discarding) begin
                    r.status = vqdm_pkg::ST_DROP;
                    if (s_last_segment) discarding = 0;
                end else begin
                    for (d = 0; d < size; d++)
                        if (!in_use[d]) break;
                    if (d >= size) begin
                        if (building) release_chain(chain_head);
                        building = 0;
                        discarding = !s_last_segment;
                        r.status = vqdm_pkg::ST_NOFREE;
                    end else begin
                        in_use[d] = 1;
                        has_next[d] = 0;
                        next_desc[d] = '0;
                        if (building) begin
                            has_next[chain_last] = 1;
                            next_desc[chain_last] = d[7:0];
                        end else begin
                            chain_head = d[7:0];
                            building = 1;
                        end
                        chain_last = d[7:0];
                        r.desc_index = d[7:0];
                        if (s_last_segment) begin
                            slot = avail_idx & (size - 1);
                            cookies[chain_head] = s_cookie_in;
                            avail_idx = avail_idx + 16'd1;
                            building = 0;
                            r.posted = 1'b1;
                            r.avail_slot = slot[7:0];
                            r.notify_queue = qid;
                        end
                    end
                end
            end
            vqdm_pkg::CMD_USED: begin
                slot = used_idx & (size - 1);
                completion_head[slot] = s_used_head;
                completion_len[slot] = s_used_length;
                used_idx = used_idx + 16'd1;
            end
            vqdm_pkg::CMD_DEQ: begin
                if (used_idx == seen_idx) begin
                    r.status = vqdm_pkg::ST_EMPTY;
                end else begin
                    slot = seen_idx & (size - 1);
                    d = completion_head[slot];
                    r.desc_index = d[7:0];
                    r.cookie_out = cookies[d];
                    cookies[d] = '0;
                    r.used_len_out = completion_len[slot];
                    release_chain(d[7:0]);
                    seen_idx = seen_idx + 16'd1;
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        vqdm_pkg::result_t want;
        vqdm_pkg::result_t pred;
        if (!aresetn) begin
            qsize_log2 = 4'd8;
            qid = '0;
            for (int i = 0; i < DEPTH; i++) in_use[i] = 0;
            avail_idx = '0;
            used_idx = '0;
            seen_idx = '0;
            chain_head = '0;
            chain_last = '0;
            building = 0;
            discarding = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, actual status %0h",
                             $time, m_status);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", 64'(want.status), 64'(m_status));
                    compare_field("desc_index", 64'(want.desc_index), 64'(m_desc_index));
                    compare_field("posted", 64'(want.posted), 64'(m_posted));
                    compare_field("avail_slot", 64'(want.avail_slot), 64'(m_avail_slot));
                    compare_field("notify_queue", 64'(want.notify_queue),
                                  64'(m_notify_queue));
                    compare_field("cookie_out", want.cookie_out, m_cookie_out);
                    compare_field("used_len_out", 64'(want.used_len_out),
                                  64'(m_used_len_out));
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    vqdm_pkg::CFG_QSIZE: qsize_log2 = cfg_data[3:0];
                    vqdm_pkg::CFG_QID:   qid = cfg_data;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_result(pred);
                expected_results.push_back(pred);
            end
        end
        mismatches <= fail_count;
        outstanding <= expected_results.size();
    end
endmodule

/* tb/virtqueue_descriptor_manager_tb.sv */
// testbench top for the virtqueue descriptor manager: stimulus, reset and verdict
`timescale 1ns / 1ps
module virtqueue_descriptor_manager_tb;
    localparam int CYCLE_LIMIT = 6000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = '0;
    logic [63:0] s_seg_addr = '0;
    logic [31:0] s_seg_len = '0;
    logic        s_device_writes = 1'b0;
    logic        s_last_segment = 1'b0;
    logic [63:0] s_cookie_in = '0;
    logic [7:0]  s_used_head = '0;
    logic [31:0] s_used_length = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [7:0]  m_desc_index;
    logic        m_posted;
    logic [7:0]  m_avail_slot;
    logic [15:0] m_notify_queue;
    logic [63:0] m_cookie_out;
    logic [31:0] m_used_len_out;

    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          quiet = 0;
    int          used_pending = 0;
    logic [1:0]  sent_cmds [$];
    bit          chain_open = 0;
    logic [7:0]  open_head = '0;
    bit          head_known [256];
    logic [7:0]  known_heads [$];
    logic [7:0]  fresh_heads [$];

    virtqueue_descriptor_manager uut (.*);

    vqdm_checker checker_i (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // learn which descriptors have been posted as chain heads
    always @(posedge aclk) begin
        logic [1:0] cmd;
        if (aresetn && m_valid && m_ready && sent_cmds.size() > 0) begin
            cmd = sent_cmds.pop_front();
            if (cmd == vqdm_pkg::CMD_ADD && m_status == vqdm_pkg::ST_OK) begin
                if (!chain_open) begin
                    open_head = m_desc_index;
                    chain_open = 1;
                end
                if (m_posted) begin
                    chain_open = 0;
                    fresh_heads.push_back(open_head);
                    if (!head_known[open_head]) begin
                        head_known[open_head] = 1;
                        known_heads.push_back(open_head);
                    end
                end
            end else if (cmd == vqdm_pkg::CMD_ADD && m_status == vqdm_pkg::ST_NOFREE) begin
                chain_open = 0;
            end
        end
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [63:0] addr,
                             input logic [31:0] len, input logic dw, input logic last,
                             input logic [63:0] cookie, input logic [7:0] head,
                             input logic [31:0] ulen);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= cmd;
        s_seg_addr <= addr;
        s_seg_len <= len;
        s_device_writes <= dw;
        s_last_segment <= last;
        s_cookie_in <= cookie;
        s_used_head <= head;
        s_used_length <= ulen;
        do @(posedge aclk); while (!s_ready);
        sent_cmds.push_back(cmd);
        if (cmd == vqdm_pkg::CMD_USED) used_pending++;
        else if (cmd == vqdm_pkg::CMD_DEQ && used_pending > 0) used_pending--;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic add_seg(input logic [63:0] addr, input logic [31:0] len,
                           input logic dw, input logic last, input logic [63:0] cookie);
        send_beat(vqdm_pkg::CMD_ADD, addr, len, dw, last, cookie, 8'($urandom()),
                  $urandom());
    endtask

    task automatic complete(input logic [7:0] head, input logic [31:0] ulen);
        send_beat(vqdm_pkg::CMD_USED, rand64(), $urandom(), 1'($urandom()), 1'($urandom()),
                  rand64(), head, ulen);
    endtask

    task automatic dequeue();
        send_beat(vqdm_pkg::CMD_DEQ, rand64(), $urandom(), 1'($urandom()), 1'($urandom()),
                  rand64(), 8'($urandom()), $urandom());
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // empty the used ring and let every result come back before touching registers
    task automatic settle();
        while (used_pending > 0) dequeue();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(input logic [3:0] log2, input logic [15:0] qid,
                             input int count, input int add_pct, input bit calm);
        int r;
        settle();
        write_reg(vqdm_pkg::CFG_QSIZE, {12'd0, log2});
        write_reg(vqdm_pkg::CFG_QID, qid);
        for (int n = 0; n < count; n++) begin
            quiet = calm || ((n / 50) % 3 == 2);
            r = $urandom_range(0, 99);
            if (r < add_pct || (r >= add_pct + 2 && r < add_pct + 2 + (98 - add_pct) / 2
                                && known_heads.size() == 0)) begin
                add_seg(rand64(), $urandom(), 1'($urandom()), $urandom_range(0, 2) == 0,
                        rand64());
            end else if (r < add_pct + 2) begin
                send_beat(vqdm_pkg::CMD_RSVD, rand64(), $urandom(), 1'($urandom()),
                          1'($urandom()), rand64(), 8'($urandom()), $urandom());
            end else if (r < add_pct + 2 + (98 - add_pct) / 2) begin
                if (fresh_heads.size() > 0 && $urandom_range(0, 3) != 0)
                    complete(fresh_heads.pop_front(), $urandom());
                else
                    complete(known_heads[$urandom_range(0, known_heads.size() - 1)],
                             $urandom());
            end else begin
                dequeue();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_reg(vqdm_pkg::CFG_QSIZE, 16'd1);
        write_reg(vqdm_pkg::CFG_QID, 16'hffff);

        // two-entry queue: empty, unused command, full rollback, drops, overrun
        dequeue();
        send_beat(vqdm_pkg::CMD_RSVD, '1, '1, 1'b1, 1'b1, '1, '1, '1);
        add_seg('1, '1, 1'b1, 1'b0, '0);
        add_seg('0, '0, 1'b0, 1'b1, '1);
        add_seg(rand64(), $urandom(), 1'b0, 1'b0, rand64());
        add_seg(rand64(), $urandom(), 1'b1, 1'b0, rand64());
        add_seg(rand64(), $urandom(), 1'b0, 1'b1, rand64());
        complete(8'd0, '1);
        dequeue();
        add_seg(rand64(), $urandom(), 1'b0, 1'b0, rand64());
        add_seg(rand64(), $urandom(), 1'b1, 1'b0, rand64());
        add_seg(rand64(), $urandom(), 1'b0, 1'b0, rand64());
        add_seg(rand64(), $urandom(), 1'b0, 1'b1, rand64());
        add_seg(rand64(), $urandom(), 1'b1, 1'b1, 64'h0123_4567_89ab_cdef);
        add_seg(rand64(), $urandom(), 1'b0, 1'b0, rand64());
        complete(8'd0, '0);
        dequeue();
        add_seg(rand64(), $urandom(), 1'b1, 1'b1, 64'hfeed_0000_beef_0001);
        complete(8'd1, 32'h1111);
        complete(8'd1, 32'h2222);
        complete(8'd1, 32'h3333);
        dequeue();
        dequeue();
        dequeue();

        run_phase(4'd0, 16'h0000, 300, 50, 0);
        run_phase(4'd15, 16'h1234, 500, 80, 0);
        run_phase(4'd3, 16'hffff, 300, 50, 0);
        run_phase(4'd8, 16'h00a5, 300, 75, 0);
        run_phase(4'd2, 16'h5a5a, 250, 45, 0);
        run_phase(4'd1, 16'h0007, 300, 50, 1);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
